### rtl/core/json_string_unescape_utf8_assert.svh
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, disabled during reset
`define JSU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons)
`define JSU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/jsu_pkg.sv
// types, codes and helpers for the json string unescaper
`default_nettype none

package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;

   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_CR = 8'h0D;
   localparam logic [7:0] CTRL_HT = 8'h09;

   localparam logic [15:0] CP_MAX_1B = 16'h007F;
   localparam logic [15:0] CP_MAX_2B = 16'h07FF;
   localparam logic [7:0]  LEAD_2B   = 8'hC0;
   localparam logic [7:0]  LEAD_3B   = 8'hE0;
   localparam logic [7:0]  CONT_MARK = 8'h80;

   localparam logic [1:0] HEX_LAST = 2'd3;

   // returns {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
// json string unescaper: quoted json bytes in, unescaped utf-8 bytes and markers out
//
//   channel | direction | ports                                   | per request
//   req     | in        | req_valid req_ready req_in_byte         | one raw byte
//   rsp     | out       | rsp_valid rsp_ready rsp_out_byte        | 0 to 3 results
//           |           | rsp_kind rsp_last                       |
//
// a byte lands in the input register, then decodes into a result group of up to
// three bytes held in the output registers; results leave one per cycle while rsp
// is ready; one request per cycle while each byte yields at most one result and rsp
// does not stall; a \u escape that encodes to 2 or 3 bytes holds the next byte back
// req_ready stays high while the input register is empty, the group is empty
// or its last result is being taken
// synchronous active-high reset clears the parser state and both valid flags
`default_nettype none

module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic            rsp_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;
   logic        hex_frozen_ff, hex_frozen_in;

   // result group registers
   logic [1:0] rem_ff;
   logic [1:0] idx_ff;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff [3];

   // decoded group for the byte in the input register
   logic [1:0] grp_n;
   logic [1:0] grp_kind;
   logic [7:0] grp_byte [3];

   logic        req_fire, rsp_fire, grp_free, move;
   logic [4:0]  hex_d;
   logic [15:0] cp_merged;
   logic        frozen_merged;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   // group can take a new decode this cycle
   assign grp_free = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);
   assign move     = in_valid_ff && grp_free;
   assign req_ready = !in_valid_ff || grp_free;

   assign in_valid_in = req_fire ? 1'b1 : (move ? 1'b0 : in_valid_ff);

   // hex accumulation, frozen by the first non-hex byte
   assign hex_d         = hex_digit(in_byte_ff);
   assign cp_merged     = (!hex_frozen_ff && hex_d[4]) ? {code_point_ff[11:0], hex_d[3:0]}
                                                       : code_point_ff;
   assign frozen_merged = hex_frozen_ff || !hex_d[4];

   // next state
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      hex_frozen_in = hex_frozen_ff;
      if (move) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (in_byte_ff == CHAR_QUOTE) mode_in = MODE_STR;
            end
            MODE_STR: begin
               if (in_byte_ff == CHAR_QUOTE) begin
                  mode_in = MODE_IDLE;
               end else if (in_byte_ff == CHAR_BSLASH) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               unique case (in_byte_ff) inside
                  CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, CHAR_B, CHAR_F,
                  CHAR_N, CHAR_R, CHAR_T: begin
                     mode_in = MODE_STR;
                  end
                  CHAR_U: begin
                     mode_in       = MODE_HEX;
                     hex_count_in  = 2'd0;
                     code_point_in = 16'd0;
                     hex_frozen_in = 1'b0;
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                  end
               endcase
            end
            MODE_HEX: begin
               if (hex_count_ff == HEX_LAST) begin
                  mode_in       = MODE_STR;
                  hex_count_in  = 2'd0;
                  code_point_in = 16'd0;
                  hex_frozen_in = 1'b0;
               end else begin
                  hex_count_in  = hex_count_ff + 2'd1;
                  code_point_in = cp_merged;
                  hex_frozen_in = frozen_merged;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // result group for the byte in the input register
   always_comb begin
      grp_n       = 2'd0;
      grp_kind    = KIND_DATA;
      grp_byte[0] = 8'd0;
      grp_byte[1] = 8'd0;
      grp_byte[2] = 8'd0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (in_byte_ff != CHAR_QUOTE) begin
               grp_n    = 2'd1;
               grp_kind = KIND_ERR;
            end
         end
         MODE_STR: begin
            if (in_byte_ff == CHAR_QUOTE) begin
               grp_n    = 2'd1;
               grp_kind = KIND_END;
            end else if (in_byte_ff != CHAR_BSLASH) begin
               grp_n       = 2'd1;
               grp_byte[0] = in_byte_ff;
            end
         end
         MODE_ESC: begin
            grp_n = 2'd1;
            unique case (in_byte_ff)
               CHAR_QUOTE:  grp_byte[0] = CHAR_QUOTE;
               CHAR_BSLASH: grp_byte[0] = CHAR_BSLASH;
               CHAR_SLASH:  grp_byte[0] = CHAR_SLASH;
               CHAR_B:      grp_byte[0] = CTRL_BS;
               CHAR_F:      grp_byte[0] = CTRL_FF;
               CHAR_N:      grp_byte[0] = CTRL_LF;
               CHAR_R:      grp_byte[0] = CTRL_CR;
               CHAR_T:      grp_byte[0] = CTRL_HT;
               CHAR_U:      grp_n       = 2'd0;
               default:     grp_kind    = KIND_ERR;
            endcase
         end
         MODE_HEX: begin
            if (hex_count_ff == HEX_LAST) begin
               // utf-8 encode; surrogates go out as plain 3-byte sequences
               if (cp_merged <= CP_MAX_1B) begin
                  grp_n       = 2'd1;
                  grp_byte[0] = cp_merged[7:0];
               end else if (cp_merged <= CP_MAX_2B) begin
                  grp_n       = 2'd2;
                  grp_byte[0] = LEAD_2B | {3'd0, cp_merged[10:6]};
                  grp_byte[1] = CONT_MARK | {2'd0, cp_merged[5:0]};
               end else begin
                  grp_n       = 2'd3;
                  grp_byte[0] = LEAD_3B | {4'd0, cp_merged[15:12]};
                  grp_byte[1] = CONT_MARK | {2'd0, cp_merged[11:6]};
                  grp_byte[2] = CONT_MARK | {2'd0, cp_merged[5:0]};
               end
            end
         end
         default: begin
            grp_n = 2'd0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= MODE_IDLE;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
         hex_frozen_ff <= 1'b0;
         rem_ff        <= 2'd0;
         idx_ff        <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
         hex_frozen_ff <= hex_frozen_in;
         if (move) begin
            rem_ff <= grp_n;
            idx_ff <= 2'd0;
         end else if (rsp_fire) begin
            rem_ff <= rem_ff - 2'd1;
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
      end
      if (move) begin
         kind_ff    <= grp_kind;
         byte_ff[0] <= grp_byte[0];
         byte_ff[1] <= grp_byte[1];
         byte_ff[2] <= grp_byte[2];
      end
   end

   // output select
   always_comb begin
      case (idx_ff)
         2'd0:    rsp_out_byte = byte_ff[0];
         2'd1:    rsp_out_byte = byte_ff[1];
         default: rsp_out_byte = byte_ff[2];
      endcase
   end

   assign rsp_valid = (rem_ff != 2'd0);
   assign rsp_kind  = kind_ff;
   assign rsp_last  = (rem_ff == 2'd1);

   // checks
`include "json_string_unescape_utf8_assert.svh"

   // end and error markers are always a single result
   `JSU_ASSERT_IMP(a_marker_single, clock, reset, (rem_ff != 2'd0 && kind_ff != KIND_DATA),
                   (rem_ff == 2'd1))
   // a group never runs past its three byte slots
   `JSU_ASSERT_IMP(a_group_bound, clock, reset, (rem_ff != 2'd0),
                   (({1'b0, idx_ff} + {1'b0, rem_ff}) <= 3'd3))
   // hex bookkeeping is clear outside a \u escape
   `JSU_ASSERT_IMP(a_hex_clear, clock, reset, (mode_ff != MODE_HEX),
                   (hex_count_ff == 2'd0 && code_point_ff == 16'd0 && !hex_frozen_ff))
   // taking the last result with nothing decoded leaves the output empty
   `JSU_ASSERT_NXT(a_drain, clock, reset, (rsp_fire && rsp_last && !move),
                   (!rsp_valid))

endmodule

`default_nettype wire

### bench/unescape_checker.sv
// unescaper checker: predicts the results of each accepted request and compares them at rsp
module unescape_checker
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_kind,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } result_type;

   result_type  owed_results[$];
   result_type  want;
   mode_type    parse_mode;
   logic [1:0]  hex_taken;
   logic [15:0] code_acc;
   logic        code_frozen;
   int          group_len;

   initial mismatch_count = 0;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      $display("mismatch %s: got %h want %h at %0t", what, got, exp_val, $realtime);
      mismatch_count++;
   endtask

   task automatic add_result(input logic [7:0] data, input logic [1:0] kind);
      result_type r;
      r.data = data;
      r.kind = kind;
      r.last = 1'b0;
      owed_results.insert(owed_results.size(), r);
      group_len++;
   endtask

   // ascii hex digit, either case
   function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
         return 1'b1;
      end
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic decode_byte(input logic [7:0] c);
      logic [3:0] nib;
      logic       is_hex;
      group_len = 0;
      case (parse_mode)
         MODE_IDLE: begin
            if (c == CHAR_QUOTE) parse_mode = MODE_STR;
            else add_result(8'h00, KIND_ERR);
         end
         MODE_STR: begin
            if (c == CHAR_QUOTE) begin
               add_result(8'h00, KIND_END);
               parse_mode = MODE_IDLE;
            end else if (c == CHAR_BSLASH) begin
               parse_mode = MODE_ESC;
            end else begin
               add_result(c, KIND_DATA);
            end
         end
         MODE_ESC: begin
            parse_mode = MODE_STR;
            case (c)
               CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: add_result(c, KIND_DATA);
               CHAR_B: add_result(CTRL_BS, KIND_DATA);
               CHAR_F: add_result(CTRL_FF, KIND_DATA);
               CHAR_N: add_result(CTRL_LF, KIND_DATA);
               CHAR_R: add_result(CTRL_CR, KIND_DATA);
               CHAR_T: add_result(CTRL_HT, KIND_DATA);
               CHAR_U: begin
                  parse_mode  = MODE_HEX;
                  hex_taken   = 2'd0;
                  code_acc    = 16'h0000;
                  code_frozen = 1'b0;
               end
               default: begin
                  add_result(8'h00, KIND_ERR);
                  parse_mode = MODE_IDLE;
               end
            endcase
         end
         default: begin
            is_hex = hex_nibble(c, nib);
            // first non-hex byte freezes the value for the rest of the escape
            if (!code_frozen && is_hex) code_acc = {code_acc[11:0], nib};
            else code_frozen = 1'b1;
            if (hex_taken == HEX_LAST) begin
               if (code_acc <= CP_MAX_1B) begin
                  add_result(code_acc[7:0], KIND_DATA);
               end else if (code_acc <= CP_MAX_2B) begin
                  add_result(LEAD_2B | {3'b000, code_acc[10:6]}, KIND_DATA);
                  add_result(CONT_MARK | {2'b00, code_acc[5:0]}, KIND_DATA);
               end else begin
                  add_result(LEAD_3B | {4'b0000, code_acc[15:12]}, KIND_DATA);
                  add_result(CONT_MARK | {2'b00, code_acc[11:6]}, KIND_DATA);
                  add_result(CONT_MARK | {2'b00, code_acc[5:0]}, KIND_DATA);
               end
               parse_mode  = MODE_STR;
               hex_taken   = 2'd0;
               code_acc    = 16'h0000;
               code_frozen = 1'b0;
            end else begin
               hex_taken = hex_taken + 2'd1;
            end
         end
      endcase
      if (group_len > 0) owed_results[owed_results.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_mode  = MODE_IDLE;
         hex_taken   = 2'd0;
         code_acc    = 16'h0000;
         code_frozen = 1'b0;
         owed_results.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing owed", rsp_out_byte, 8'h00);
            end else begin
               want = owed_results.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", {6'd0, rsp_kind}, {6'd0, want.kind});
               if (rsp_last !== want.last)
                  report_mismatch("last", {7'd0, rsp_last}, {7'd0, want.last});
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

### bench/tb.sv
// unescaper testbench top: clock, reset, request and response traffic, verdict
module tb
   import jsu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 280;  // random requests after the opening sequence
   localparam int QUIET_TAIL   = 40;   // last requests run with no idling on either side
   localparam int HOLD_AT      = 120;  // random request count at which rsp holds off
   localparam int HOLD_CYCLES  = 48;   // length of that hold-off
   localparam int STALL_LIMIT  = 1000; // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES = 16;   // tail after the last owed result

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_ready   = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last;
   int         mismatch_count;
   int         results_owed;

   int   items_sent   = 0;
   int   random_start = 0;
   int   idle_cycles  = 0;
   logic calm         = 1'b0;  // this string goes through with no idling
   logic quiet        = 1'b0;  // end of run: no idling at all
   logic hold_rsp     = 1'b0;  // asks the rsp side for one long hold-off
   logic hold_asked   = 1'b0;

   // opening sequence: error in idle, byte extremes inside the string, a surrogate
   // in mixed case, a \u with no digit at all (quote, backslash, sign, space), a \u
   // frozen after one digit by an 'x', close, reopen, unknown escape
   logic [7:0] opening_bytes [26] = '{
      8'hFF, CHAR_QUOTE, 8'h00, 8'hFF,
      CHAR_BSLASH, CHAR_U, 8'h44, 8'h38, 8'h33, 8'h64,
      CHAR_BSLASH, CHAR_U, CHAR_QUOTE, CHAR_BSLASH, 8'h2B, 8'h20,
      CHAR_BSLASH, CHAR_U, 8'h37, 8'h78, 8'h46, 8'h46,
      CHAR_QUOTE, CHAR_QUOTE, CHAR_BSLASH, 8'h71
   };

   logic [7:0] simple_escapes [8] = '{
      CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T
   };

   // code points on the edges of the utf-8 length classes and the surrogate block
   logic [15:0] cp_edges [8] = '{
      16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF
   };

   always #5 clock = ~clock;

   json_string_unescape_utf8 dut (.*);

   unescape_checker u_checker (.*);

   // ascii hex digit for a nibble, letters in random case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // offer one request, with an occasional gap in front, and wait for the handshake
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // one piece of string content: plain byte, simple escape, clean \u or messy \u
   task automatic send_token();
      logic [7:0]  b;
      logic [15:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_QUOTE || b == CHAR_BSLASH);
            send_byte(b);
         end
         4, 5: begin
            send_byte(CHAR_BSLASH);
            send_byte(simple_escapes[$urandom_range(0, 7)]);
         end
         6, 7, 8: begin
            // spread over the 1, 2 and 3 byte encodings, surrogates and the edges
            case ($urandom_range(0, 4))
               0:       cp = 16'($urandom_range(0, 'h7F));
               1:       cp = 16'($urandom_range('h80, 'h7FF));
               2:       cp = 16'($urandom_range('h800, 'hFFFF));
               3:       cp = 16'($urandom_range('hD800, 'hDFFF));
               default: cp = cp_edges[$urandom_range(0, 7)];
            endcase
            send_byte(CHAR_BSLASH);
            send_byte(CHAR_U);
            for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4]));
         end
         default: begin
            // any byte may sit among the four, quote and backslash included
            send_byte(CHAR_BSLASH);
            send_byte(CHAR_U);
            repeat (4) begin
               if ($urandom_range(0, 1)) b = hex_char(4'($urandom));
               else b = 8'($urandom_range(0, 255));
               send_byte(b);
            end
         end
      endcase
   endtask

   // mostly well-formed strings; some junk in idle and some end on a bad escape
   task automatic send_string();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) begin
         do b = 8'($urandom_range(0, 255));
         while (b == CHAR_QUOTE);
         send_byte(b);
      end
      send_byte(CHAR_QUOTE);
      repeat ($urandom_range(0, 10)) send_token();
      if ($urandom_range(0, 9) == 0) begin
         do b = 8'($urandom_range(0, 255));
         while (b inside {CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, CHAR_B, CHAR_F,
                          CHAR_N, CHAR_R, CHAR_T, CHAR_U});
         send_byte(CHAR_BSLASH);
         send_byte(b);
      end else begin
         send_byte(CHAR_QUOTE);
      end
   endtask

   // request side and verdict
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         if (!hold_asked && items_sent - random_start >= HOLD_AT) begin
            hold_asked = 1'b1;
            hold_rsp   = 1'b1;
         end
         calm = ($urandom_range(0, 3) == 0);
         send_string();
      end
      req_valid <= 1'b0;
      // look at the owed count between edges, once the checker is done with the edge
      do @(negedge clock);
      while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   // response side: ready stretches, short stalls, and one long hold-off while
   // the request side keeps offering so that the block fills up
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // watchdog: too long without a handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
